// ===== hdl/quat_key_normalize_hemisphere_assert.svh =====
// Assertion macros for the rotation-key normalizer.
`ifndef QUAT_KEY_NORMALIZE_HEMISPHERE_ASSERT_SVH
`define QUAT_KEY_NORMALIZE_HEMISPHERE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QKNH_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quat_key_normalize_hemisphere: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define QKNH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quat_key_normalize_hemisphere: next-cycle check failed");

`endif

// ===== hdl/qknh_pkg.sv =====
// Shared constants of the rotation-key normalizer.
package qknh_pkg;

  localparam int IN_WIDTH_DEF      = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int OUT_WIDTH         = 16;

endpackage

// ===== hdl/qknh_if.sv =====
// Valid/ready channel interfaces for input keys and normalized result keys.
interface qknh_in_if #(
  parameter int IN_WIDTH = qknh_pkg::IN_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] in_x;
  logic signed [IN_WIDTH-1:0] in_y;
  logic signed [IN_WIDTH-1:0] in_z;
  logic signed [IN_WIDTH-1:0] in_w;
  logic                       track_start;

  modport source (output valid, in_x, in_y, in_z, in_w, track_start, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, track_start, output ready);
endinterface

interface qknh_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qknh_pkg::OUT_WIDTH-1:0] out_x;
  logic signed [qknh_pkg::OUT_WIDTH-1:0] out_y;
  logic signed [qknh_pkg::OUT_WIDTH-1:0] out_z;
  logic signed [qknh_pkg::OUT_WIDTH-1:0] out_w;
  logic                                 degenerate;
  logic                                 flipped;

  modport source (output valid, out_x, out_y, out_z, out_w, degenerate, flipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, degenerate, flipped, output ready);
endinterface

// ===== hdl/quat_key_normalize_hemisphere.sv =====
// Rotation-key normalizer with hemisphere continuity (top level).
//
//   Channel   Direction  Word contents
//   in_chan   in         x, y, z, w (signed Q4.12), track_start
//   out_chan  out        x, y, z, w (signed, OUT_FRAC_BITS fraction), degenerate, flipped
//
// A key's run time is set by the bit-serial search of each component through one shared
// three-input adder and comparator; the result word loads after the search and the dot
// product terms, once the result register is free. A zero-length key skips the search.
// A single shared multiplier forms the squares and the dot product terms.
// The result register lets the next key be taken while a result waits on a stall.
// Reset is synchronous; it clears the sequencer, the result valid and the stored key.
`include "quat_key_normalize_hemisphere_assert.svh"

module quat_key_normalize_hemisphere #(
  parameter int IN_WIDTH      = qknh_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = qknh_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  qknh_in_if.sink      in_chan,
  qknh_out_if.source   out_chan
);

  localparam int QW = OUT_FRAC_BITS + 2;
  localparam int MW = (IN_WIDTH > QW) ? IN_WIDTH : QW;
  localparam int SW = 2 * IN_WIDTH + 1;
  localparam int XW = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 3;
  localparam int DW = 2 * OUT_FRAC_BITS + 6;
  localparam int BW = $clog2(OUT_FRAC_BITS + 2);
  localparam int SH = 2 * OUT_FRAC_BITS + 2;
  localparam int OW = qknh_pkg::OUT_WIDTH;
  localparam logic [BW-1:0]        BIT_TOP = BW'(OUT_FRAC_BITS + 1);
  localparam logic [QW-1:0]        K_MAX   = QW'(1) << (OUT_FRAC_BITS + 1);
  localparam logic signed [QW-1:0] ONE_Q   = QW'(1) << OUT_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_INIT,
    S_SRCH,
    S_DOT,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [BW-1:0]          bit_r, bit_nxt;
  logic signed [IN_WIDTH-1:0] c_r [4];
  logic signed [IN_WIDTH-1:0] c_nxt [4];
  logic                   ts_r, ts_nxt;
  logic [SW-1:0]          sum_r, sum_nxt;
  logic [XW-1:0]          m_r, m_nxt;
  logic [XW-1:0]          p_r, p_nxt;
  logic [XW-1:0]          a_r, a_nxt;
  logic [XW-1:0]          b_r, b_nxt;
  logic [QW-1:0]          k_r, k_nxt;
  logic signed [QW-1:0]   q_r [4];
  logic signed [QW-1:0]   q_nxt [4];
  logic signed [QW-1:0]   prev_r [4];
  logic signed [QW-1:0]   prev_nxt [4];
  logic signed [DW-1:0]   dot_r, dot_nxt;
  logic                   degen_r, degen_nxt;
  logic                   open_r, open_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [OW-1:0]   out_x_r, out_x_nxt;
  logic signed [OW-1:0]   out_y_r, out_y_nxt;
  logic signed [OW-1:0]   out_z_r, out_z_nxt;
  logic signed [OW-1:0]   out_w_r, out_w_nxt;
  logic                   out_degen_r, out_degen_nxt;
  logic                   out_flip_r, out_flip_nxt;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;
  logic [SW-1:0]          sq;
  logic [SW-1:0]          sum_add;
  logic [XW-1:0]          trial;
  logic                   hit;
  logic [QW-1:0]          k_fin;
  logic [QW-1:0]          m_mag;
  logic signed [QW-1:0]   q_new;
  logic                   flip;
  logic signed [QW-1:0]   q_fin [4];
  logic                   out_xyz_zero;

  always_comb begin
    case (state_r)
      S_DOT: begin
        mul_a = MW'(prev_r[idx_r]);
        mul_b = MW'(q_r[idx_r]);
      end
      default: begin
        mul_a = MW'(c_r[idx_r]);
        mul_b = MW'(c_r[idx_r]);
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign sq      = SW'($unsigned(mul_p));
  assign sum_add = sum_r + sq;
  assign trial   = p_r + b_r + a_r;
  assign hit     = (trial <= m_r);
  assign k_fin   = hit ? (k_r | (QW'(1) << bit_r)) : k_r;
  assign m_mag   = (k_fin + QW'(1)) >> 1;
  assign q_new   = c_r[idx_r][IN_WIDTH-1] ? -$signed(m_mag) : $signed(m_mag);
  assign flip    = open_r && !ts_r && (dot_r < 0);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_fin[i] = flip ? -q_r[i] : q_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    c_nxt         = c_r;
    ts_nxt        = ts_r;
    sum_nxt       = sum_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    q_nxt         = q_r;
    prev_nxt      = prev_r;
    dot_nxt       = dot_r;
    degen_nxt     = degen_r;
    open_nxt      = open_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_w_nxt     = out_w_r;
    out_degen_nxt = out_degen_r;
    out_flip_nxt  = out_flip_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          c_nxt[0]  = in_chan.in_x;
          c_nxt[1]  = in_chan.in_y;
          c_nxt[2]  = in_chan.in_z;
          c_nxt[3]  = in_chan.in_w;
          ts_nxt    = in_chan.track_start;
          sum_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sum_nxt = sum_add;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          if (sum_add == '0) begin
            degen_nxt = 1'b1;
            q_nxt[0]  = '0;
            q_nxt[1]  = '0;
            q_nxt[2]  = '0;
            q_nxt[3]  = ONE_Q;
            dot_nxt   = '0;
            state_nxt = S_DOT;
          end else begin
            degen_nxt = 1'b0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        m_nxt     = XW'(sq) << SH;
        a_nxt     = XW'(sum_r) << SH;
        p_nxt     = '0;
        b_nxt     = '0;
        k_nxt     = '0;
        bit_nxt   = BIT_TOP;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        k_nxt = k_fin;
        a_nxt = a_r >> 2;
        if (hit) begin
          p_nxt = trial;
          b_nxt = (b_r >> 1) + a_r;
        end else begin
          b_nxt = b_r >> 1;
        end
        if (bit_r == '0) begin
          q_nxt[idx_r] = q_new;
          idx_nxt      = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            dot_nxt   = '0;
            state_nxt = S_DOT;
          end else begin
            state_nxt = S_INIT;
          end
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      S_DOT: begin
        dot_nxt = dot_r + DW'(mul_p);
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = OW'(q_fin[0]);
          out_y_nxt     = OW'(q_fin[1]);
          out_z_nxt     = OW'(q_fin[2]);
          out_w_nxt     = OW'(q_fin[3]);
          out_degen_nxt = degen_r;
          out_flip_nxt  = flip;
          prev_nxt      = q_fin;
          open_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      open_r      <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      open_r      <= open_nxt;
      prev_r      <= prev_nxt;
      idx_r       <= idx_nxt;
      bit_r       <= bit_nxt;
      c_r         <= c_nxt;
      ts_r        <= ts_nxt;
      sum_r       <= sum_nxt;
      m_r         <= m_nxt;
      p_r         <= p_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      k_r         <= k_nxt;
      q_r         <= q_nxt;
      dot_r       <= dot_nxt;
      degen_r     <= degen_nxt;
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
      out_z_r     <= out_z_nxt;
      out_w_r     <= out_w_nxt;
      out_degen_r <= out_degen_nxt;
      out_flip_r  <= out_flip_nxt;
    end
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_x      = out_x_r;
  assign out_chan.out_y      = out_y_r;
  assign out_chan.out_z      = out_z_r;
  assign out_chan.out_w      = out_w_r;
  assign out_chan.degenerate = out_degen_r;
  assign out_chan.flipped    = out_flip_r;

  assign out_xyz_zero = (out_x_r == '0) && (out_y_r == '0) && (out_z_r == '0);

  `QKNH_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready)
  `QKNH_ASSERT_NOW(a_degenerate_identity, out_valid_r && out_degen_r, out_xyz_zero)
  `QKNH_ASSERT_NOW(a_search_bound, state_r == S_SRCH, k_r <= K_MAX)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the rotation-key normalizer with hemisphere continuity.
`timescale 1ns / 100ps

module testbench;

  localparam int IN_WIDTH_DEF      = qknh_pkg::IN_WIDTH_DEF;
  localparam int OUT_FRAC_BITS_DEF = qknh_pkg::OUT_FRAC_BITS_DEF;
  localparam int OUT_WIDTH         = qknh_pkg::OUT_WIDTH;

  localparam int KEY_COUNT     = 1150;
  localparam int STALL_AT_KEY  = 200;
  localparam int STALL_CYCLES  = 600;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic signed [IN_WIDTH_DEF-1:0] x;
    logic signed [IN_WIDTH_DEF-1:0] y;
    logic signed [IN_WIDTH_DEF-1:0] z;
    logic signed [IN_WIDTH_DEF-1:0] w;
    logic                           track_start;
    bit                             hold;
  } key_word_t;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] x;
    logic signed [OUT_WIDTH-1:0] y;
    logic signed [OUT_WIDTH-1:0] z;
    logic signed [OUT_WIDTH-1:0] w;
    logic                        degenerate;
    logic                        flipped;
  } norm_word_t;

  logic clk;
  logic rst_n;

  qknh_in_if #(.IN_WIDTH(IN_WIDTH_DEF)) in_chan();
  qknh_out_if out_chan();

  quat_key_normalize_hemisphere #(
    .IN_WIDTH      (IN_WIDTH_DEF),
    .OUT_FRAC_BITS (OUT_FRAC_BITS_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  key_word_t  pending_keys[$];
  norm_word_t norm_expected[$];

  longint last_norm[4] = '{0, 0, 0, 0};
  bit     track_live   = 1'b0;

  int keys_accepted = 0;
  int mismatches    = 0;
  bit key_taken     = 1'b0;
  bit result_taken  = 1'b0;
  bit calm          = 1'b0;
  int send_gap      = 0;
  int drain_gap     = 0;
  int sink_hold     = 0;
  bit stall_done    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // Rounded |c| * 2^F / sqrt(energy), halves away from zero, found by bisection.
  function automatic longint unsigned round_scaled(longint unsigned mag, logic [127:0] energy);
    logic [127:0]    limit;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned odd;
    limit = (128'(mag) * 128'(mag)) << (2 * OUT_FRAC_BITS_DEF + 2);
    lo = 0;
    hi = longint'(1) << OUT_FRAC_BITS_DEF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 2 * mid - 1;
      if (energy * (128'(odd) * 128'(odd)) <= limit) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  function automatic norm_word_t normalize_key(key_word_t key);
    longint          comp[4];
    longint unsigned mag[4];
    longint          q[4];
    logic [127:0]    energy;
    longint          dot;
    norm_word_t      res;
    comp[0] = key.x;
    comp[1] = key.y;
    comp[2] = key.z;
    comp[3] = key.w;
    energy = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
      energy = energy + 128'(mag[i]) * 128'(mag[i]);
    end
    res.degenerate = (energy == 0);
    res.flipped = 1'b0;
    if (res.degenerate) begin
      q = '{0, 0, 0, longint'(1) << OUT_FRAC_BITS_DEF};
    end else begin
      for (int i = 0; i < 4; i++) begin
        q[i] = longint'(round_scaled(mag[i], energy));
        if (comp[i] < 0) q[i] = -q[i];
      end
    end
    if (track_live && !key.track_start) begin
      dot = 0;
      for (int i = 0; i < 4; i++) dot += last_norm[i] * q[i];
      if (dot < 0) begin
        res.flipped = 1'b1;
        for (int i = 0; i < 4; i++) q[i] = -q[i];
      end
    end
    last_norm = q;
    track_live = 1'b1;
    res.x = OUT_WIDTH'(q[0]);
    res.y = OUT_WIDTH'(q[1]);
    res.z = OUT_WIDTH'(q[2]);
    res.w = OUT_WIDTH'(q[3]);
    return res;
  endfunction

  function automatic int clamp_q412(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_component();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 31) - 16;
      2: return $urandom_range(0, 8191) - 4096;
      default: begin
        case ($urandom_range(0, 2))
          0: return -32768;
          1: return 32767;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  function automatic void queue_key(int x, int y, int z, int w, bit ts, bit hold);
    key_word_t k;
    k.x = IN_WIDTH_DEF'(x);
    k.y = IN_WIDTH_DEF'(y);
    k.z = IN_WIDTH_DEF'(z);
    k.w = IN_WIDTH_DEF'(w);
    k.track_start = ts;
    k.hold = hold;
    pending_keys.insert(pending_keys.size(), k);
  endfunction

  always @(negedge clk) begin
    key_word_t nxt;
    bit        may_send;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || key_taken) begin
      if (key_taken) send_gap = pick_gap();
      may_send = (send_gap == 0) && (pending_keys.size() != 0);
      if (may_send && pending_keys[0].hold && norm_expected.size() != 0) may_send = 1'b0;
      if (send_gap != 0) send_gap--;
      if (may_send) begin
        nxt = pending_keys.pop_front();
        in_chan.in_x        <= nxt.x;
        in_chan.in_y        <= nxt.y;
        in_chan.in_z        <= nxt.z;
        in_chan.in_w        <= nxt.w;
        in_chan.track_start <= nxt.track_start;
        in_chan.valid       <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (result_taken) drain_gap = pick_gap();
      if (sink_hold != 0 || drain_gap != 0) begin
        out_chan.ready <= 1'b0;
        if (sink_hold == 0) drain_gap--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // The long receiver stall that backs the block up into its input.
  always @(negedge clk) begin
    if (keys_accepted == STALL_AT_KEY && !stall_done) begin
      sink_hold  <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end
  end

  always @(posedge clk) begin
    key_word_t  seen;
    norm_word_t want;
    norm_word_t got;
    key_taken    <= rst_n && in_chan.valid && in_chan.ready;
    result_taken <= rst_n && out_chan.valid && out_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      seen.x = in_chan.in_x;
      seen.y = in_chan.in_y;
      seen.z = in_chan.in_z;
      seen.w = in_chan.in_w;
      seen.track_start = in_chan.track_start;
      seen.hold = 1'b0;
      want = normalize_key(seen);
      norm_expected.insert(norm_expected.size(), want);
      keys_accepted++;
      if ($urandom_range(0, 49) == 0) calm <= !calm;
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.x = out_chan.out_x;
      got.y = out_chan.out_y;
      got.z = out_chan.out_z;
      got.w = out_chan.out_w;
      got.degenerate = out_chan.degenerate;
      got.flipped = out_chan.flipped;
      if (norm_expected.size() == 0) begin
        mismatches++;
        $display("%0t: expected no word, got x=%0d y=%0d z=%0d w=%0d deg=%0b flip=%0b",
                 $time, got.x, got.y, got.z, got.w, got.degenerate, got.flipped);
      end else begin
        want = norm_expected.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.w !== want.w ||
            got.degenerate !== want.degenerate || got.flipped !== want.flipped) begin
          mismatches++;
          $display("%0t: expected x=%0d y=%0d z=%0d w=%0d deg=%0b flip=%0b,",
                   $time, want.x, want.y, want.z, want.w, want.degenerate, want.flipped,
                   " got x=%0d y=%0d z=%0d w=%0d deg=%0b flip=%0b",
                   got.x, got.y, got.z, got.w, got.degenerate, got.flipped);
        end
      end
    end
  end

  initial begin
    int cur[4];
    int track_len;
    bit ts;
    int total;
    rst_n = 1'b0;

    // The first key after reset opens a track even without track_start.
    queue_key(0, 0, 0, -4096, 0, 0);
    queue_key(0, 0, 0, 0, 0, 0);
    queue_key(0, 0, 0, 0, 1, 0);
    queue_key(-32768, -32768, -32768, -32768, 0, 0);
    queue_key(32767, 32767, 32767, 32767, 0, 0);
    queue_key(32767, -32768, 32767, -32768, 1, 0);
    queue_key(-32768, 0, 0, 0, 1, 0);
    queue_key(32767, 0, 0, 0, 0, 0);
    queue_key(1, 0, 0, 0, 1, 0);
    queue_key(0, -1, 0, 0, 0, 0);
    queue_key(4096, 0, 0, 0, 1, 0);
    queue_key(0, 4096, 0, 0, 0, 0);
    queue_key(-4096, 1, 0, 0, 0, 0);
    queue_key(0, -4096, 0, 0, 0, 0);
    queue_key(-1, -1, -1, -1, 1, 0);
    queue_key(1, 2, 3, 4, 0, 0);
    queue_key(-3, 5, -7, 11, 0, 0);
    queue_key(3, 4, 0, 0, 1, 0);
    queue_key(1, 1, 1, 0, 0, 0);
    queue_key(0, 0, -32768, 32767, 0, 0);
    queue_key(0, 0, 0, 0, 0, 1);

    while (pending_keys.size() < KEY_COUNT) begin
      track_len = $urandom_range(1, 12);
      for (int i = 0; i < 4; i++) cur[i] = rand_component();
      for (int k = 0; k < track_len; k++) begin
        if (k != 0) begin
          for (int i = 0; i < 4; i++) cur[i] = clamp_q412(cur[i] + $urandom_range(0, 1023) - 512);
          if ($urandom_range(0, 1) == 1)
            for (int i = 0; i < 4; i++) cur[i] = clamp_q412(-cur[i]);
        end
        ts = (k == 0);
        if ($urandom_range(0, 19) == 0) ts = $urandom_range(0, 1);
        if ($urandom_range(0, 24) == 0) begin
          queue_key(0, 0, 0, 0, ts, 0);
        end else if ($urandom_range(0, 9) == 0) begin
          queue_key(rand_component(), rand_component(), rand_component(), rand_component(),
                    $urandom_range(0, 1), 0);
        end else begin
          queue_key(cur[0], cur[1], cur[2], cur[3], ts, $urandom_range(0, 119) == 0);
        end
      end
    end
    total = pending_keys.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (keys_accepted < total || norm_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
